/* design/ild_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ild_pkg
// Shared types and constants for the interrupt level dispatcher.
// ----------------------------------------------------------------------------
package ild_pkg;

	localparam int DEF_NUM_SOURCES = 96;
	localparam int WORD_BITS       = 32;
	localparam int FIELD_W         = 4;
	localparam int INDEX_W         = 7;
	localparam int POS_W           = 5;
	localparam int LEVEL_W         = 4;

	localparam logic [FIELD_W-1:0] LEVEL_OFFSET = 4'd7;
	localparam logic [FIELD_W-1:0] FIELD_MAX    = 4'd8;
	localparam logic [LEVEL_W-1:0] LVL_HW_ERROR = 4'd5;
	localparam logic [LEVEL_W-1:0] LVL_TIMER    = 4'd6;

	typedef enum logic [1:0] {
		MODE_ASSIGN,
		MODE_ENABLE,
		MODE_READ,
		MODE_DISPATCH
	} mode_t;

	typedef enum logic [1:0] {
		KIND_DEVICE,
		KIND_HW_ERROR,
		KIND_TIMER,
		KIND_RAISE
	} kind_t;

	// register write controls from the front end to the storage
	typedef struct packed {
		logic                 assign_we;
		logic                 enable_we;
		logic [INDEX_W-1:0]   index;
		logic [WORD_BITS-1:0] wdata;
	} wr_t;

	// what one lane found in its 32-source word
	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] pos;
	} lane_res_t;

endpackage

/* design/ild_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ild_regs
// Level field and enable mask storage, padded to whole 32-source words.
// ----------------------------------------------------------------------------
module ild_regs
	import ild_pkg::*;
#(
	parameter int NUM_SOURCES = DEF_NUM_SOURCES,
	parameter int NUM_WORDS   = (NUM_SOURCES + WORD_BITS - 1) / WORD_BITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  wr_t                                      wr,
	output logic [NUM_WORDS*WORD_BITS-1:0][FIELD_W-1:0] fields,
	output logic [NUM_WORDS*WORD_BITS-1:0]           enables
);

	logic [NUM_SOURCES-1:0][FIELD_W-1:0] field_q;
	logic [NUM_SOURCES-1:0]              enable_q;

	for (genvar s = 0; s < NUM_SOURCES; s++) begin : g_src
		localparam int ASSIGN_WORD = s / 8;
		localparam int SLOT        = s % 8;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				field_q[s]  <= '0;
				enable_q[s] <= 1'b0;
			end else begin
				if (wr.assign_we && wr.index == INDEX_W'(ASSIGN_WORD)) begin
					field_q[s] <= wr.wdata[SLOT*FIELD_W +: FIELD_W];
				end
				if (wr.enable_we && wr.index == INDEX_W'(s)) begin
					enable_q[s] <= 1'b1;
				end
			end
		end
	end

	// sources past the top read as disabled
	always_comb begin
		fields                    = '0;
		enables                   = '0;
		fields[NUM_SOURCES-1:0]   = field_q;
		enables[NUM_SOURCES-1:0]  = enable_q;
	end

endmodule

/* design/ild_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ild_lane
// One 32-source word: level match, enable and pending qualify, top-bit pick.
// ----------------------------------------------------------------------------
module ild_lane
	import ild_pkg::*;
#(
	parameter int NUM_SOURCES = DEF_NUM_SOURCES,
	parameter int LANE        = 0
) (
	input  logic [WORD_BITS-1:0][FIELD_W-1:0] fields,
	input  logic [WORD_BITS-1:0]              enables,
	input  logic [WORD_BITS-1:0]              pending,
	input  logic [LEVEL_W-1:0]                level,
	output lane_res_t                         res
);

	logic [WORD_BITS-1:0] cand;

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			cand[b] = (LANE * WORD_BITS + b < NUM_SOURCES)
				&& (fields[b] <= FIELD_MAX)
				&& ((5'(fields[b]) + 5'(LEVEL_OFFSET)) == 5'(level))
				&& enables[b] && pending[b];
		end
	end

	// highest set bit wins
	always_comb begin
		res.hit = |cand;
		res.pos = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (cand[b]) begin
				res.pos = POS_W'(b);
			end
		end
	end

endmodule

/* design/ild_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ild_merge
// Combines lane results: lowest word with a hit wins, else a fallback kind.
// ----------------------------------------------------------------------------
module ild_merge
	import ild_pkg::*;
#(
	parameter int NUM_WORDS = 3
) (
	input  lane_res_t           lanes [NUM_WORDS],
	input  logic [LEVEL_W-1:0]  level,
	output kind_t               kind,
	output logic [INDEX_W-1:0]  source
);

	logic found;

	always_comb begin
		found  = 1'b0;
		source = '0;
		for (int w = NUM_WORDS - 1; w >= 0; w--) begin
			if (lanes[w].hit) begin
				found  = 1'b1;
				source = INDEX_W'(w * WORD_BITS) | INDEX_W'(lanes[w].pos);
			end
		end
	end

	always_comb begin
		priority if (found) begin
			kind = KIND_DEVICE;
		end else if (level == LVL_HW_ERROR) begin
			kind = KIND_HW_ERROR;
		end else if (level == LVL_TIMER) begin
			kind = KIND_TIMER;
		end else begin
			kind = KIND_RAISE;
		end
	end

endmodule

/* design/interrupt_level_dispatcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_level_dispatcher
// Interrupt controller: per-source level assignment, enable mask, dispatch.
//
//  channel  dir  tdata (low bit up)                         tuser
//  s_*      in   index, write_data, level, pending_low,     mode
//                pending_mid, pending_high, 5 pad bits
//  m_*      out  source_number, read_data, 1 pad bit        status, handler_kind
//
//  Result is registered at the accepting edge and offered on m_* from the next
//  cycle; one transaction per cycle while m_tready is high.
//  Dispatch runs one lane per 32-source word plus a merge, all combinational.
//  Reset clears all level fields (every source on level 7) and all enables.
//  s_tready drops only while a result is held by a stalled m_tready.
// ----------------------------------------------------------------------------
module interrupt_level_dispatcher
	import ild_pkg::*;
#(
	parameter int NUM_SOURCES = DEF_NUM_SOURCES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// index, write_data, level, pending_low, pending_mid, pending_high
	input  logic [143:0] s_tdata,
	// mode
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// source_number, read_data
	output logic [39:0]  m_tdata,
	// status, handler_kind
	output logic [2:0]   m_tuser
);

	localparam int NUM_WORDS    = (NUM_SOURCES + WORD_BITS - 1) / WORD_BITS;
	localparam int ASSIGN_WORDS = (NUM_SOURCES + 7) / 8;

	mode_t                  mode;
	logic [INDEX_W-1:0]     index;
	logic [WORD_BITS-1:0]   write_data;
	logic [LEVEL_W-1:0]     level;
	logic [3*WORD_BITS-1:0] pending;
	logic                   accept;
	wr_t                    wr;

	assign mode       = mode_t'(s_tuser);
	assign index      = s_tdata[6:0];
	assign write_data = s_tdata[38:7];
	assign level      = s_tdata[42:39];
	assign pending    = s_tdata[138:43];

	logic m_tvalid_q;
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	logic bad_assign, bad_source, bad_word;
	assign bad_assign = index >= INDEX_W'(ASSIGN_WORDS);
	assign bad_source = index >= INDEX_W'(NUM_SOURCES);
	assign bad_word   = index >= INDEX_W'(NUM_WORDS);

	always_comb begin
		wr.assign_we = accept && mode == MODE_ASSIGN && !bad_assign;
		wr.enable_we = accept && mode == MODE_ENABLE && !bad_source;
		wr.index     = index;
		wr.wdata     = write_data;
	end

	logic [NUM_WORDS*WORD_BITS-1:0][FIELD_W-1:0] fields;
	logic [NUM_WORDS*WORD_BITS-1:0]              enables;

	ild_regs #(
		.NUM_SOURCES(NUM_SOURCES),
		.NUM_WORDS  (NUM_WORDS)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.fields (fields),
		.enables(enables)
	);

	lane_res_t lanes [NUM_WORDS];

	for (genvar w = 0; w < NUM_WORDS; w++) begin : g_lane
		ild_lane #(
			.NUM_SOURCES(NUM_SOURCES),
			.LANE       (w)
		) u_lane (
			.fields (fields[w*WORD_BITS +: WORD_BITS]),
			.enables(enables[w*WORD_BITS +: WORD_BITS]),
			.pending(pending[w*WORD_BITS +: WORD_BITS]),
			.level  (level),
			.res    (lanes[w])
		);
	end

	kind_t              merge_kind;
	logic [INDEX_W-1:0] merge_src;

	ild_merge #(
		.NUM_WORDS(NUM_WORDS)
	) u_merge (
		.lanes (lanes),
		.level (level),
		.kind  (merge_kind),
		.source(merge_src)
	);

	logic [WORD_BITS-1:0] mask_word;

	always_comb begin
		mask_word = '0;
		for (int w = 0; w < NUM_WORDS; w++) begin
			if (index == INDEX_W'(w)) begin
				mask_word = enables[w*WORD_BITS +: WORD_BITS];
			end
		end
	end

	logic                 status_d;
	kind_t                kind_d;
	logic [INDEX_W-1:0]   src_d;
	logic [WORD_BITS-1:0] rdata_d;

	always_comb begin
		status_d = 1'b0;
		kind_d   = KIND_DEVICE;
		src_d    = '0;
		rdata_d  = '0;
		unique case (mode)
			MODE_ASSIGN: begin
				status_d = bad_assign;
			end
			MODE_ENABLE: begin
				status_d = bad_source;
			end
			MODE_READ: begin
				status_d = bad_word;
				if (!bad_word) begin
					rdata_d = mask_word;
				end
			end
			MODE_DISPATCH: begin
				kind_d = merge_kind;
				src_d  = merge_src;
			end
			default: begin
				status_d = 1'b0;
			end
		endcase
	end

	logic                 status_q;
	kind_t                kind_q;
	logic [INDEX_W-1:0]   src_q;
	logic [WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			kind_q   <= kind_d;
			src_q    <= src_d;
			rdata_q  <= rdata_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, rdata_q, src_q};
	assign m_tuser  = {kind_q, status_q};

	// every accepted transaction shows up on the output the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted transaction produced no result");

	// fallback kinds never carry a source number
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind_q != KIND_DEVICE |-> src_q == '0)
		else $error("source number set on non-device kind");

	// a parameter error leaves no read data and no dispatch
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status_q |-> rdata_q == '0 && kind_q == KIND_DEVICE && src_q == '0)
		else $error("payload on parameter error");

	// chosen source always lies within the implemented range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> src_q < INDEX_W'(NUM_SOURCES))
		else $error("source number out of range");

endmodule
